// ===== design/trpm_pkg.sv =====
// Shared types and constants for the touch report parser.
package trpm_pkg;

  // Defaults for the top-level parameters
  localparam int BODY_LEN_DEF     = 13;
  localparam int POINT_STRIDE_DEF = 6;
  localparam int MAX_POINTS_DEF   = 2;

  // Fixed field widths
  localparam int IDX_W   = 4;
  localparam int POS_W   = 3;
  localparam int SLOT_W  = 2;
  localparam int CNT_W   = 2;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int CFG_A_W = 3;

  localparam logic [3:0]   NIBBLE_MASK   = 4'hF;
  localparam logic [1:0]   EVENT_MASK    = 2'h3;
  localparam logic [3:0]   MAX_STATUS    = 4'd2;
  localparam logic [1:0]   LIFT_UP_EVENT = 2'd1;
  localparam logic [11:0]  COORD_MAX     = 12'hFFF;

  // Byte positions inside one point slot
  localparam logic [POS_W-1:0] POS_EVT_XH = 3'd0;
  localparam logic [POS_W-1:0] POS_XL     = 3'd1;
  localparam logic [POS_W-1:0] POS_YH     = 3'd2;
  localparam logic [POS_W-1:0] POS_YL     = 3'd3;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_SCR_WIDTH  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SCR_HEIGHT = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_SWAP_AXES  = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_FLIP_X     = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_FLIP_Y     = 3'd4;

  // Result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         touch_event;
    logic               id;
    logic [CNT_W-1:0]   count;
  } op_t;

  typedef struct packed {
    logic [SIZE_W-1:0] scr_width;
    logic [SIZE_W-1:0] scr_height;
    logic              swap_axes;
    logic              flip_x;
    logic              flip_y;
  } cfg_t;

endpackage

// ===== design/trpm_front.sv =====
// Front end: byte counter, slot decode, point assembly and end-of-sample results.
module trpm_front #(
  parameter int BODY_LEN     = trpm_pkg::BODY_LEN_DEF,
  parameter int POINT_STRIDE = trpm_pkg::POINT_STRIDE_DEF,
  parameter int MAX_POINTS   = trpm_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          start_of_burst,
  output logic          push,
  output trpm_pkg::op_t push_op
);
  import trpm_pkg::*;

  localparam logic [IDX_W-1:0]  BODY_END  = IDX_W'(BODY_LEN);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BODY_LEN - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(POINT_STRIDE - 1);
  localparam logic [CNT_W-1:0]  MAXP      = CNT_W'(MAX_POINTS);

  logic [IDX_W-1:0]   byte_index_r, byte_index_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   status_r, status_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic [1:0]         event_r, event_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [3:0]         yh_r, yh_nxt;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   active;

  assign idx    = start_of_burst ? '0 : byte_index_r;
  assign active = (status_r < MAXP) ? status_r : MAXP;

  always_comb begin
    byte_index_nxt = byte_index_r;
    pos_nxt        = pos_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    kept_nxt       = kept_r;
    event_nxt      = event_r;
    x_nxt          = x_r;
    yh_nxt         = yh_r;
    push           = 1'b0;
    push_op        = '0;
    if (acc) begin
      byte_index_nxt = idx;
      if (idx < BODY_END) begin
        if (idx == '0) begin
          status_nxt     = ((data_byte[3:0] & NIBBLE_MASK) > MAX_STATUS) ? '0 : data_byte[1:0];
          kept_nxt       = '0;
          byte_index_nxt = IDX_W'(1);
          pos_nxt        = '0;
          slot_nxt       = '0;
        end else begin
          if (slot_r < active) begin
            case (pos_r)
              POS_EVT_XH: begin
                event_nxt = data_byte[7:6] & EVENT_MASK;
                x_nxt     = {data_byte[3:0] & NIBBLE_MASK, 8'h00};
              end
              POS_XL: x_nxt = {x_r[11:8], data_byte};
              POS_YH: yh_nxt = data_byte[3:0] & NIBBLE_MASK;
              POS_YL: begin
                if (idx < LAST_IDX && event_r != LIFT_UP_EVENT && kept_r < MAXP) begin
                  push                = 1'b1;
                  push_op.kind        = KIND_POINT;
                  push_op.x           = x_r;
                  push_op.y           = {yh_r, data_byte};
                  push_op.touch_event = event_r;
                  push_op.id          = kept_r[0];
                  push_op.count       = kept_r + CNT_W'(1);
                  kept_nxt            = kept_r + CNT_W'(1);
                end
              end
              default: ;
            endcase
          end
          if (idx == LAST_IDX) begin
            push          = 1'b1;
            push_op       = '0;
            push_op.kind  = KIND_END;
            push_op.count = kept_r;
          end
          byte_index_nxt = idx + IDX_W'(1);
          // advance the slot position, wrap at the stride
          if (pos_r == LAST_POS) begin
            pos_nxt = '0;
            if (slot_r != '1) slot_nxt = slot_r + SLOT_W'(1);
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      pos_r        <= '0;
      slot_r       <= '0;
      status_r     <= '0;
      kept_r       <= '0;
      event_r      <= '0;
      x_r          <= '0;
      yh_r         <= '0;
    end else begin
      byte_index_r <= byte_index_nxt;
      pos_r        <= pos_nxt;
      slot_r       <= slot_nxt;
      status_r     <= status_nxt;
      kept_r       <= kept_nxt;
      event_r      <= event_nxt;
      x_r          <= x_nxt;
      yh_r         <= yh_nxt;
    end
  end

endmodule

// ===== design/trpm_queue.sv =====
// Two-entry queue of decoded results between front and back end.
module trpm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trpm_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output trpm_pkg::op_t head
);
  import trpm_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/trpm_back.sv =====
// Back end: coordinate swap, mirror and clamp of points when mapping is on, then the output register.
module trpm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  trpm_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  trpm_pkg::op_t q_head,
  output logic          q_pop,
  input  logic          out_take,
  output logic          out_valid,
  output trpm_pkg::op_t out_op
);
  import trpm_pkg::*;

  localparam int SW = 15;

  logic              valid_r, valid_nxt;
  op_t               op_r, op_nxt;
  logic              map_en;
  logic [COORD_W-1:0] a, b;
  logic signed [SW-1:0] a_s, b_s;

  function automatic logic [COORD_W-1:0] clamp_axis(input logic signed [SW-1:0] v,
                                                    input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] hi;
    logic [COORD_W-1:0] res;
    begin
      hi = (size > {1'b0, COORD_MAX} + SIZE_W'(1)) ? {1'b0, COORD_MAX} : size - SIZE_W'(1);
      if (v < 0) res = '0;
      else if (v > $signed({2'b00, hi})) res = hi[COORD_W-1:0];
      else res = v[COORD_W-1:0];
      return res;
    end
  endfunction

  assign map_en = (cfg.scr_width != '0) && (cfg.scr_height != '0);
  assign a      = cfg.swap_axes ? q_head.y : q_head.x;
  assign b      = cfg.swap_axes ? q_head.x : q_head.y;
  assign a_s    = cfg.flip_x ? $signed({2'b00, cfg.scr_width}) - SW'(1) - $signed({3'b000, a})
                             : $signed({3'b000, a});
  assign b_s    = cfg.flip_y ? $signed({2'b00, cfg.scr_height}) - SW'(1) - $signed({3'b000, b})
                             : $signed({3'b000, b});

  // take a new item whenever the output slot is free or being drained
  assign q_pop = q_valid && (!valid_r || out_take);

  always_comb begin
    valid_nxt = valid_r;
    op_nxt    = op_r;
    if (out_take) valid_nxt = 1'b0;
    if (q_pop) begin
      valid_nxt = 1'b1;
      op_nxt    = q_head;
      if (q_head.kind == KIND_POINT && map_en) begin
        op_nxt.x = clamp_axis(a_s, cfg.scr_width);
        op_nxt.y = clamp_axis(b_s, cfg.scr_height);
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  assign out_valid = valid_r;
  assign out_op    = op_r;

endmodule

// ===== design/touch_report_parse_map_core.sv =====
// A byte that causes a result goes into the queue, then into the output register that drives out_tvalid.
// Throughput: one byte per cycle while the result side takes one item per cycle.
// At most one result per byte; a two-entry queue and an output register absorb stalls,
// and in_tready drops only while the queue holds two items.
// Reset (rst_n, synchronous, active low) clears the byte counter, counts, queue
// and configuration; the first byte after reset is taken as the status byte.
module touch_report_parse_map_core #(
  parameter int BODY_LEN     = trpm_pkg::BODY_LEN_DEF,
  parameter int POINT_STRIDE = trpm_pkg::POINT_STRIDE_DEF,
  parameter int MAX_POINTS   = trpm_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] start_of_burst
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [11:0] point_x, [23:12] point_y, [25:24] touch_event, [26] point_id,
  // [28:27] point_count, [31:29] zero
  output logic [31:0]                   out_tdata,
  output logic                          out_tuser,  // [0] result_kind
  // configuration writes
  input  logic                          cfg_we,
  input  logic [trpm_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [trpm_pkg::SIZE_W-1:0]   cfg_wdata
);
  import trpm_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_acc;
  logic push;
  op_t  push_op;
  logic q_full, q_valid, q_pop;
  op_t  q_head;
  logic out_valid;
  op_t  out_op;

  // Configuration registers: plain write, unknown indexes dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SCR_WIDTH:  cfg_nxt.scr_width  = cfg_wdata;
        REG_SCR_HEIGHT: cfg_nxt.scr_height = cfg_wdata;
        REG_SWAP_AXES:  cfg_nxt.swap_axes  = cfg_wdata[0];
        REG_FLIP_X:     cfg_nxt.flip_x     = cfg_wdata[0];
        REG_FLIP_Y:     cfg_nxt.flip_y     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else cfg_r <= cfg_nxt;
  end

  // Hold off input only when the queue has no room for a possible result
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  trpm_front #(
    .BODY_LEN     (BODY_LEN),
    .POINT_STRIDE (POINT_STRIDE),
    .MAX_POINTS   (MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .data_byte      (in_tdata),
    .start_of_burst (in_tuser),
    .push           (push),
    .push_op        (push_op)
  );

  trpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  trpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_take  (out_tvalid && out_tready),
    .out_valid (out_valid),
    .out_op    (out_op)
  );

  assign out_tvalid = out_valid;
  assign out_tuser  = out_op.kind;
  assign out_tdata  = {3'b000, out_op.count, out_op.id, out_op.touch_event,
                       out_op.y, out_op.x};

`ifndef SYNTH
  // A result is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("result pushed into full queue");

  // The end-of-sample count never exceeds the point limit
  a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_END) |-> (out_op.count <= CNT_W'(MAX_POINTS)))
    else $error("end count above point limit");

  // With mapping on, a point lies inside the panel
  a_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_POINT && cfg_r.scr_width != '0 &&
     cfg_r.scr_height != '0)
    |-> ({1'b0, out_op.x} < cfg_r.scr_width && {1'b0, out_op.y} < cfg_r.scr_height))
    else $error("mapped point outside panel");
`endif

endmodule
